// ----- rtl/bhv_pkg.sv -----
// bmp header validator: shared constants and types
// no dependencies; used by bhv_eval and bmp_header_validator_core

package bhv_pkg;

   // header layout, byte positions from the start of the file
   localparam int HdrLen    = 54;
   localparam int OfsPixels = 10;
   localparam int OfsWidth  = 18;
   localparam int OfsHeight = 22;
   localparam int OfsBpp    = 28;

   // field widths
   localparam int CountW  = 6;
   localparam int StrideW = 18;
   localparam int SizeW   = 34;
   localparam int SideW   = 16;

   // accepted format
   localparam logic [7:0]  MagicB  = 8'h42;
   localparam logic [7:0]  MagicM  = 8'h4D;
   localparam logic [15:0] BppTrue = 16'd24;
   localparam logic [31:0] MaxSide = 32'd65535;
   localparam logic [31:0] HeightMin = 32'h8000_0000;

   // captured header fields handed to the check stage
   typedef struct packed {
      logic        magic_ok;
      logic [15:0] bits;
      logic [31:0] offset;
      logic [31:0] width;
      logic [31:0] height;
   } hdr_fields_type;

endpackage

// ----- rtl/bhv_req_if.sv -----
// bmp header validator: header byte channel
// depends on nothing

interface bhv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       start_req;

   modport source (output valid, output header_byte, output start_req, input ready);
   modport sink   (input valid, input header_byte, input start_req, output ready);
endinterface

// ----- rtl/bhv_rsp_if.sv -----
// bmp header validator: result channel
// depends on nothing

interface bhv_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic        rows_top_first;
   logic [17:0] line_pitch;
   logic [33:0] pixel_data_size;
   logic [31:0] pixel_start;

   modport source (output valid, output status, output image_width, output image_height,
                   output rows_top_first, output line_pitch, output pixel_data_size,
                   output pixel_start, input ready);
   modport sink   (input valid, input status, input image_width, input image_height,
                   input rows_top_first, input line_pitch, input pixel_data_size,
                   input pixel_start, output ready);
endinterface

// ----- rtl/bhv_eval.sv -----
// bmp header validator: two-stage check of the captured header and result register
// depends on bhv_pkg and bhv_rsp_if

module bhv_eval #(
   parameter logic [31:0] MaxSide = bhv_pkg::MaxSide
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  bhv_pkg::hdr_fields_type fields,
   input  logic [31:0]             file_length,
   output logic                    slot_free,
   bhv_rsp_if.source               rsp_chan
);

   // stage one registers
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_bad_ff;
   logic        s1_neg_ff;
   logic [15:0] s1_w_ff;
   logic [15:0] s1_h_ff;
   logic [17:0] s1_stride_ff;
   logic [31:0] s1_avail_ff;
   logic [31:0] s1_offset_ff;

   // result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic        status_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic        top_first_ff;
   logic [17:0] stride_ff;
   logic [33:0] size_ff;
   logic [31:0] start_ff;

   logic        s1_adv;
   logic        neg;
   logic [31:0] h_mag;
   logic        bad1;
   logic [17:0] stride;
   logic [33:0] size;
   logic        bad2;

   // stage one: field checks, magnitude, stride and room left after the offset
   always_comb begin
      neg   = fields.height[31];
      h_mag = neg ? (~fields.height + 32'd1) : fields.height;
      bad1  = (file_length < 32'(bhv_pkg::HdrLen))
           || !fields.magic_ok
           || (fields.bits != bhv_pkg::BppTrue)
           || (fields.offset < 32'(bhv_pkg::HdrLen))
           || (fields.offset > file_length)
           || fields.width[31]
           || (fields.width == 32'd0)
           || (fields.height == 32'd0)
           || (fields.height == bhv_pkg::HeightMin)
           || (fields.width > MaxSide)
           || (h_mag > MaxSide);
      // width times three plus three, rounded down to a multiple of four
      stride = ({2'b00, fields.width[15:0]} + {1'b0, fields.width[15:0], 1'b0} + 18'd3)
             & ~18'd3;
   end

   // stage two: data size against the bytes after the pixel offset
   assign size = 34'(s1_stride_ff) * 34'(s1_h_ff);
   assign bad2 = s1_bad_ff || (size > {2'b00, s1_avail_ff});

   // handshake between the stages
   assign s1_adv    = !rsp_valid_ff || rsp_chan.ready;
   assign slot_free = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (load) begin
         s1_bad_ff    <= bad1;
         s1_neg_ff    <= neg;
         s1_w_ff      <= fields.width[15:0];
         s1_h_ff      <= h_mag[15:0];
         s1_stride_ff <= stride;
         s1_avail_ff  <= file_length - fields.offset;
         s1_offset_ff <= fields.offset;
      end
   end

   // result payload, zero geometry on error
   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         status_ff    <= bad2;
         width_ff     <= bad2 ? 16'd0 : s1_w_ff;
         height_ff    <= bad2 ? 16'd0 : s1_h_ff;
         top_first_ff <= bad2 ? 1'b0 : s1_neg_ff;
         stride_ff    <= bad2 ? 18'd0 : s1_stride_ff;
         size_ff      <= bad2 ? 34'd0 : size;
         start_ff     <= bad2 ? 32'd0 : s1_offset_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = status_ff;
   assign rsp_chan.image_width     = width_ff;
   assign rsp_chan.image_height    = height_ff;
   assign rsp_chan.rows_top_first  = top_first_ff;
   assign rsp_chan.line_pitch      = stride_ff;
   assign rsp_chan.pixel_data_size = size_ff;
   assign rsp_chan.pixel_start     = start_ff;

endmodule

// ----- rtl/bmp_header_validator_core.sv -----
// bmp header validator top level: byte counter, field capture, length register
// depends on bhv_pkg, bhv_req_if, bhv_rsp_if and bhv_eval
//
//  channel   dir  handshake            payload
//  req_chan  in   valid / ready        header_byte, start_req
//  rsp_chan  out  valid / ready        status, geometry, pixel_start
//  csr       in   csr_wr_en            csr_wr_data (file length)
//
// one header byte is taken per cycle while ready is high; 54 bytes give one result.
// after the 54th byte is accepted the stage one registers hold the field checks,
// then the result register takes the stride by height multiply and size compare.
// reset clears the count, the captured fields and the file length to zero.
// a stalled result holds in the output register; bytes keep flowing until a
// second finished header is waiting behind it, then req ready drops.

module bmp_header_validator_core #(
   parameter logic [31:0] MaxSide = bhv_pkg::MaxSide
) (
   input  logic        clock,
   input  logic        reset,
   bhv_req_if.sink     req_chan,
   bhv_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [5:0]  count_ff, count_in;
   logic        magic_ff, magic_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [31:0] length_ff;

   logic        accept;
   logic [5:0]  pos;
   logic        take;
   logic        load;
   logic        slot_free;
   logic [1:0]  off_lane, wid_lane, hgt_lane;
   logic        bpp_lane;
   logic [7:0]  hbyte;
   bhv_pkg::hdr_fields_type fields;

   assign accept = req_chan.valid && slot_free;
   assign hbyte  = req_chan.header_byte;

   // position of this word; a start request restarts at zero
   assign pos  = req_chan.start_req ? 6'd0 : count_ff;
   assign take = accept && (pos < 6'(bhv_pkg::HdrLen));
   assign load = take && (pos == 6'(bhv_pkg::HdrLen - 1));

   assign off_lane = 2'(pos - 6'(bhv_pkg::OfsPixels));
   assign wid_lane = 2'(pos - 6'(bhv_pkg::OfsWidth));
   assign hgt_lane = 2'(pos - 6'(bhv_pkg::OfsHeight));
   assign bpp_lane = 1'(pos - 6'(bhv_pkg::OfsBpp));

   // field capture, little endian lanes
   always_comb begin
      count_in  = count_ff;
      magic_in  = magic_ff;
      bits_in   = bits_ff;
      offset_in = offset_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (accept && req_chan.start_req) begin
         count_in = 6'd0;
      end
      if (take) begin
         count_in = pos + 6'd1;
         case (pos) inside
            6'd0: begin
               magic_in = (hbyte == bhv_pkg::MagicB);
            end
            6'd1: begin
               magic_in = magic_ff && (hbyte == bhv_pkg::MagicM);
            end
            [6'(bhv_pkg::OfsPixels) : 6'(bhv_pkg::OfsPixels + 3)]: begin
               offset_in[off_lane*8 +: 8] = hbyte;
            end
            [6'(bhv_pkg::OfsWidth) : 6'(bhv_pkg::OfsWidth + 3)]: begin
               width_in[wid_lane*8 +: 8] = hbyte;
            end
            [6'(bhv_pkg::OfsHeight) : 6'(bhv_pkg::OfsHeight + 3)]: begin
               height_in[hgt_lane*8 +: 8] = hbyte;
            end
            [6'(bhv_pkg::OfsBpp) : 6'(bhv_pkg::OfsBpp + 1)]: begin
               bits_in[bpp_lane*8 +: 8] = hbyte;
            end
            default: begin
            end
         endcase
      end
   end

   // capture state and file length register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 6'd0;
         magic_ff  <= 1'b0;
         bits_ff   <= 16'd0;
         offset_ff <= 32'd0;
         width_ff  <= 32'd0;
         height_ff <= 32'd0;
         length_ff <= 32'd0;
      end else begin
         count_ff  <= count_in;
         magic_ff  <= magic_in;
         bits_ff   <= bits_in;
         offset_ff <= offset_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         if (csr_wr_en) begin
            length_ff <= csr_wr_data;
         end
      end
   end

   assign fields.magic_ok = magic_ff;
   assign fields.bits     = bits_ff;
   assign fields.offset   = offset_ff;
   assign fields.width    = width_ff;
   assign fields.height   = height_ff;

   assign req_chan.ready = slot_free;

   // header checks and result register
   bhv_eval #(
      .MaxSide (MaxSide)
   ) u_eval (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .fields      (fields),
      .file_length (length_ff),
      .slot_free   (slot_free),
      .rsp_chan    (rsp_chan)
   );

endmodule
